// ===== rtl/worst_fit_region_allocator_assert.svh =====
// Assertion macros used by wfra_ctrl. Each expects clk and arst_n in scope.
`ifndef WORST_FIT_REGION_ALLOCATOR_ASSERT_SVH
`define WORST_FIT_REGION_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define WFRA_AST_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wfra assertion failed");

// next-cycle implication
`define WFRA_AST_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wfra assertion failed");

`endif

// ===== rtl/wfra_pkg.sv =====
`timescale 1ns / 1ps
package wfra_pkg;
	localparam int DEF_MAX_REGIONS = 16;
	localparam int DEF_ADDR_BITS   = 20;
	localparam int DEF_OWNER_BITS  = 16;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic REG_MEMORY_SIZE = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVAL,
		ST_SHIFT,
		ST_PLACE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic re;
		logic we;
	} mem_ctl_t;
endpackage

// ===== rtl/wfra_req_if.sv =====
`timescale 1ns / 1ps
interface wfra_req_if #(
	parameter int OWNER_BITS = 16,
	parameter int ADDR_BITS  = 20
);
	logic                  valid;
	logic                  ready;
	logic                  action;
	logic [OWNER_BITS-1:0] owner_id;
	logic [ADDR_BITS:0]    request_size;

	modport source(output valid, action, owner_id, request_size, input ready);
	modport sink(input valid, action, owner_id, request_size, output ready);
endinterface

// ===== rtl/wfra_rsp_if.sv =====
`timescale 1ns / 1ps
interface wfra_rsp_if #(
	parameter int ADDR_BITS = 20
);
	logic               valid;
	logic               ready;
	logic [ADDR_BITS:0] region_start;
	logic               ok;

	modport source(output valid, region_start, ok, input ready);
	modport sink(input valid, region_start, ok, output ready);
endinterface

// ===== rtl/wfra_table.sv =====
`timescale 1ns / 1ps
module wfra_table
	import wfra_pkg::*;
#(
	parameter int MAX_REGIONS = DEF_MAX_REGIONS,
	parameter int ADDR_BITS   = DEF_ADDR_BITS,
	parameter int OWNER_BITS  = DEF_OWNER_BITS,
	localparam int SW = ADDR_BITS + 1,
	localparam int IW = $clog2(MAX_REGIONS)
) (
	input  logic                  clk,
	input  mem_ctl_t              ctl,
	input  logic [IW-1:0]         raddr,
	input  logic [IW-1:0]         waddr,
	input  logic [OWNER_BITS-1:0] wowner,
	input  logic [SW-1:0]         wbegin,
	input  logic [SW-1:0]         wfinish,
	output logic [OWNER_BITS-1:0] rowner,
	output logic [SW-1:0]         rbegin,
	output logic [SW-1:0]         rfinish
);
	logic [OWNER_BITS-1:0] owner_mem  [MAX_REGIONS];
	logic [SW-1:0]         begin_mem  [MAX_REGIONS];
	logic [SW-1:0]         finish_mem [MAX_REGIONS];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			owner_mem[waddr]  <= wowner;
			begin_mem[waddr]  <= wbegin;
			finish_mem[waddr] <= wfinish;
		end
		if (ctl.re) begin
			rowner  <= owner_mem[raddr];
			rbegin  <= begin_mem[raddr];
			rfinish <= finish_mem[raddr];
		end
	end
endmodule

// ===== rtl/wfra_ctrl.sv =====
`timescale 1ns / 1ps
`include "worst_fit_region_allocator_assert.svh"
module wfra_ctrl
	import wfra_pkg::*;
#(
	parameter int MAX_REGIONS = DEF_MAX_REGIONS,
	parameter int ADDR_BITS   = DEF_ADDR_BITS,
	parameter int OWNER_BITS  = DEF_OWNER_BITS,
	localparam int SW = ADDR_BITS + 1,
	localparam int IW = $clog2(MAX_REGIONS),
	localparam int CW = $clog2(MAX_REGIONS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [SW-1:0]         memory_size,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_action,
	input  logic [OWNER_BITS-1:0] in_owner,
	input  logic [SW-1:0]         in_size,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SW-1:0]         out_start,
	output logic                  out_ok,
	output mem_ctl_t              mem_ctl,
	output logic [IW-1:0]         mem_raddr,
	output logic [IW-1:0]         mem_waddr,
	output logic [OWNER_BITS-1:0] mem_wowner,
	output logic [SW-1:0]         mem_wbegin,
	output logic [SW-1:0]         mem_wfinish,
	input  logic [OWNER_BITS-1:0] mem_rowner,
	input  logic [SW-1:0]         mem_rbegin,
	input  logic [SW-1:0]         mem_rfinish
);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REGIONS);

	state_t                state_q, state_n;
	logic [CW-1:0]         cnt_q, k_q, best_idx_q, n_q;
	logic [SW-1:0]         cursor_q, best_left_q, best_start_q, len_q;
	logic                  found_q, hit_q, op_q;
	logic [IW-1:0]         hit_idx_q, src_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic                  w_s1;
	logic [IW-1:0]         dst_s1;
	logic                  ov_q, ok_q, res_ok_q;
	logic [SW-1:0]         start_q, res_start_q;

	logic                  accept, early_fail, proc_c, take_c, fits_c, eval_ok;
	logic [SW-1:0]         hole_end_c, diff_c, left_c;
	logic [CW-1:0]         cand_idx_c;
	logic                  shift_idle;

	assign accept     = in_valid && in_ready;
	assign early_fail = (in_action == ACT_ALLOC) &&
		((in_size == '0) || (in_size > memory_size) || (cnt_q == MAX_CNT));
	assign proc_c     = (state_q == ST_SCAN) && (k_q != '0);
	assign hole_end_c = (state_q == ST_EVAL) ? memory_size : mem_rbegin;
	assign cand_idx_c = (state_q == ST_EVAL) ? cnt_q : k_q - CW'(1);
	assign diff_c     = hole_end_c - cursor_q;
	assign fits_c     = (hole_end_c > cursor_q) && (diff_c >= len_q);
	assign left_c     = diff_c - len_q;
	assign take_c     = fits_c && (!found_q || (left_c > best_left_q));
	assign eval_ok    = (op_q == ACT_ALLOC) ? (found_q || take_c) : hit_q;
	assign shift_idle = (n_q == '0) && !w_s1;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:  if (accept) state_n = early_fail ? ST_DONE : ST_SCAN;
			ST_SCAN:  if (k_q == cnt_q) state_n = ST_EVAL;
			ST_EVAL:  state_n = eval_ok ? ST_SHIFT : ST_DONE;
			ST_SHIFT: if (shift_idle) state_n = (op_q == ACT_ALLOC) ? ST_PLACE : ST_DONE;
			ST_PLACE: state_n = ST_DONE;
			ST_DONE:  if (!ov_q || out_ready) state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		mem_ctl.re  = 1'b0;
		mem_ctl.we  = 1'b0;
		mem_raddr   = k_q[IW-1:0];
		mem_waddr   = dst_s1;
		mem_wowner  = mem_rowner;
		mem_wbegin  = mem_rbegin;
		mem_wfinish = mem_rfinish;
		case (state_q)
			ST_SCAN: mem_ctl.re = (k_q < cnt_q);
			ST_SHIFT: begin
				mem_ctl.re = (n_q != '0);
				mem_raddr  = src_q;
				mem_ctl.we = w_s1;
			end
			ST_PLACE: begin
				mem_ctl.we  = 1'b1;
				mem_waddr   = best_idx_q[IW-1:0];
				mem_wowner  = owner_q;
				mem_wbegin  = best_start_q;
				mem_wfinish = best_start_q + len_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
			w_s1    <= 1'b0;
			n_q     <= '0;
		end else begin
			state_q <= state_n;
			if ((state_q == ST_DONE) && (!ov_q || out_ready)) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (accept) begin
					op_q        <= in_action;
					owner_q     <= in_owner;
					len_q       <= in_size;
					k_q         <= '0;
					cursor_q    <= '0;
					found_q     <= 1'b0;
					hit_q       <= 1'b0;
					res_ok_q    <= 1'b0;
					res_start_q <= (in_action == ACT_ALLOC) ? memory_size : '0;
				end
				ST_SCAN: begin
					if (k_q != cnt_q) k_q <= k_q + CW'(1);
					if (proc_c) begin
						if (take_c) begin
							found_q      <= 1'b1;
							best_left_q  <= left_c;
							best_start_q <= cursor_q;
							best_idx_q   <= cand_idx_c;
						end
						if (mem_rfinish > cursor_q) cursor_q <= mem_rfinish;
						if (!hit_q && (mem_rowner == owner_q)) begin
							hit_q     <= 1'b1;
							hit_idx_q <= cand_idx_c[IW-1:0];
						end
					end
				end
				ST_EVAL: begin
					if (take_c) begin
						found_q      <= 1'b1;
						best_start_q <= cursor_q;
						best_idx_q   <= cand_idx_c;
					end
					if (op_q == ACT_ALLOC) begin
						src_q <= cnt_q[IW-1:0] - IW'(1);
						n_q   <= cnt_q - (take_c ? cand_idx_c : best_idx_q);
					end else begin
						src_q <= hit_idx_q + IW'(1);
						n_q   <= hit_q ? (cnt_q - CW'(1) - CW'(hit_idx_q)) : '0;
					end
				end
				ST_SHIFT: begin
					w_s1 <= (n_q != '0);
					if (n_q != '0) begin
						n_q <= n_q - CW'(1);
						if (op_q == ACT_ALLOC) begin
							src_q  <= src_q - IW'(1);
							dst_s1 <= src_q + IW'(1);
						end else begin
							src_q  <= src_q + IW'(1);
							dst_s1 <= src_q - IW'(1);
						end
					end
					if (shift_idle && (op_q == ACT_FREE)) begin
						cnt_q    <= cnt_q - CW'(1);
						res_ok_q <= 1'b1;
					end
				end
				ST_PLACE: begin
					cnt_q       <= cnt_q + CW'(1);
					res_ok_q    <= 1'b1;
					res_start_q <= best_start_q;
				end
				ST_DONE: if (!ov_q || out_ready) begin
					ok_q    <= res_ok_q;
					start_q <= res_start_q;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = ov_q;
	assign out_ok    = ok_q;
	assign out_start = start_q;

	`WFRA_AST_IMP(a_cnt_range, 1'b1, cnt_q <= MAX_CNT)
	`WFRA_AST_IMP(a_shift_no_overlap, mem_ctl.re && mem_ctl.we, mem_raddr != mem_waddr)
	`WFRA_AST_IMP(a_place_room, state_q == ST_PLACE, best_idx_q <= cnt_q && cnt_q < MAX_CNT)
	`WFRA_AST_NXT(a_accept_busy, accept, state_q != ST_IDLE)
endmodule

// ===== rtl/worst_fit_region_allocator.sv =====
`timescale 1ns / 1ps
// Worst-fit contiguous region allocator.
// Requests arrive on req (valid/ready): action 0 allocates request_size units
// for owner_id, action 1 frees that owner's lowest-addressed region.
// Each request gives one transfer on rsp: region_start and ok. A failed
// allocate returns memory_size with ok low; a free always returns zero.
// memory_size is written over the APB port when paddr[AW-1] is low. The user
// must write it only while idle; the block itself does not enforce this.
// With N regions held, the controller scans the N table entries for holes,
// checks the tail hole, moves entries through the region table (one read
// and one write port), writes the insert for an allocate and latches the
// result. The next request can be taken as rsp valid comes up. Rejected
// allocations (zero, too big, table full) skip straight to the result.
// One request is in flight at a time; the next is taken once the result is
// latched in the output register, even while rsp is stalled. A stalled rsp
// holds its transfer and blocks the next result only.
// Reset empties the table and sets memory_size to 2^ADDR_BITS; no clearing
// pass is needed.
module worst_fit_region_allocator
	import wfra_pkg::*;
#(
	parameter int MAX_REGIONS = DEF_MAX_REGIONS,
	parameter int ADDR_BITS   = DEF_ADDR_BITS,
	parameter int OWNER_BITS  = DEF_OWNER_BITS,
	localparam int SW = ADDR_BITS + 1,
	localparam int DW = (SW > 32) ? 64 : 32,
	localparam int AW = (SW > 32) ? 4 : 3
) (
	input  logic          clk,
	input  logic          arst_n,
	wfra_req_if.sink      req,
	wfra_rsp_if.source    rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [AW-1:0] paddr,
	input  logic [DW-1:0] pwdata,
	output logic [DW-1:0] prdata,
	output logic          pready
);
	localparam int IW = $clog2(MAX_REGIONS);

	logic [SW-1:0]         memory_size_q;
	mem_ctl_t              mem_ctl;
	logic [IW-1:0]         mem_raddr, mem_waddr;
	logic [OWNER_BITS-1:0] mem_wowner, mem_rowner;
	logic [SW-1:0]         mem_wbegin, mem_wfinish, mem_rbegin, mem_rfinish;
	logic                  reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[AW-1] == REG_MEMORY_SIZE);
	assign prdata  = reg_hit ? DW'(memory_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			memory_size_q <= SW'(1) << ADDR_BITS;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			memory_size_q <= pwdata[SW-1:0];
		end
	end

	wfra_ctrl #(
		.MAX_REGIONS(MAX_REGIONS),
		.ADDR_BITS  (ADDR_BITS),
		.OWNER_BITS (OWNER_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.memory_size(memory_size_q),
		.in_valid   (req.valid),
		.in_ready   (req.ready),
		.in_action  (req.action),
		.in_owner   (req.owner_id),
		.in_size    (req.request_size),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.out_start  (rsp.region_start),
		.out_ok     (rsp.ok),
		.mem_ctl    (mem_ctl),
		.mem_raddr  (mem_raddr),
		.mem_waddr  (mem_waddr),
		.mem_wowner (mem_wowner),
		.mem_wbegin (mem_wbegin),
		.mem_wfinish(mem_wfinish),
		.mem_rowner (mem_rowner),
		.mem_rbegin (mem_rbegin),
		.mem_rfinish(mem_rfinish)
	);

	wfra_table #(
		.MAX_REGIONS(MAX_REGIONS),
		.ADDR_BITS  (ADDR_BITS),
		.OWNER_BITS (OWNER_BITS)
	) u_table (
		.clk    (clk),
		.ctl    (mem_ctl),
		.raddr  (mem_raddr),
		.waddr  (mem_waddr),
		.wowner (mem_wowner),
		.wbegin (mem_wbegin),
		.wfinish(mem_wfinish),
		.rowner (mem_rowner),
		.rbegin (mem_rbegin),
		.rfinish(mem_rfinish)
	);
endmodule
